>>> hdl/tnrs_pkg.sv
// ----------------------------------------------------------------------------
// Top-N record selector package
// Shared constants, record and control types for the selector and its cells.
// ----------------------------------------------------------------------------
package tnrs_pkg;

    localparam int CAPACITY = 32;
    localparam int MAX_EMIT = 32;
    localparam int CNT_W    = $clog2(MAX_EMIT + 1);
    localparam int RANK_W   = 5;
    localparam int TOPN_W   = 6;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic REG_SORT_KEY = 1'b0;
    localparam logic REG_TOP_N    = 1'b1;

    localparam logic KEY_CPU    = 1'b0;
    localparam logic KEY_MEMORY = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [31:0] id;
        logic [15:0] cpu;
        logic [47:0] mem;
        logic [2:0]  status;
    } rec_t;

    typedef struct packed {
        logic insert;
        logic shift_up;
        logic clear;
    } chain_cmd_t;

    typedef enum logic {
        ST_FILL,
        ST_EMIT
    } state_t;

endpackage

>>> hdl/top_n_record_selector.sv
// ----------------------------------------------------------------------------
// Top-N record selector
// Keeps a ranked chain of process records and emits the leading ones per list.
// ----------------------------------------------------------------------------
// Records are taken one beat per cycle and inserted into a chain of CAPACITY
// cells that stays sorted by the selected key, highest first, smaller id first
// on ties. The beat marked list_end is inserted like the others; the block then
// stops taking input and emits one result beat per cycle, while out_ready is
// high, from the head of the chain, up to top_n records (all kept records when
// top_n is zero, never more than 32), after which the chain is empty and input
// resumes. When the chain is full the lowest-ranked record falls off and
// overflow is reported on every result of that list.
module top_n_record_selector
    import tnrs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          proc_id,
    input  logic [15:0]          cpu_centi,
    input  logic [47:0]          mem_bytes,
    input  logic [2:0]           run_state,
    input  logic                 list_end,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [RANK_W-1:0]    rank,
    output logic [31:0]          out_id,
    output logic [15:0]          out_cpu_centi,
    output logic [47:0]          out_mem_bytes,
    output logic [2:0]           out_run_state,
    output logic                 overflow,
    output logic                 run_last
);

    state_t             state_reg;
    state_t             state_next;
    logic               sort_key_reg;
    logic               sort_key_next;
    logic [TOPN_W-1:0]  top_n_reg;
    logic [TOPN_W-1:0]  top_n_next;
    logic [CNT_W-1:0]   emit_cnt_reg;
    logic [CNT_W-1:0]   emit_cnt_next;
    logic               dropped_reg;
    logic               dropped_next;
    logic [CNT_W-1:0]   limit;
    logic               in_beat;
    logic               out_beat;
    logic               cfg_write;
    logic               full;
    logic               second_valid;
    rec_t               head;
    rec_t               new_rec;
    chain_cmd_t         cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        sort_key_next = sort_key_reg;
        top_n_next    = top_n_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SORT_KEY: sort_key_next = pwdata[0];
                REG_TOP_N:    top_n_next    = pwdata[TOPN_W-1:0];
                default:      sort_key_next = sort_key_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SORT_KEY: prdata = {{(DATA_W-1){1'b0}}, sort_key_reg};
            REG_TOP_N:    prdata = {{(DATA_W-TOPN_W){1'b0}}, top_n_reg};
            default:      prdata = '0;
        endcase
    end

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    assign limit = ((top_n_reg == '0) || (top_n_reg > TOPN_W'(MAX_EMIT))) ?
                   CNT_W'(MAX_EMIT) : CNT_W'(top_n_reg);

    assign run_last = ((emit_cnt_reg + CNT_W'(1)) == limit) || !second_valid;

    assign new_rec = '{valid: 1'b1, id: proc_id, cpu: cpu_centi,
                       mem: mem_bytes, status: run_state};

    assign cmd = '{insert: in_beat, shift_up: out_beat && !run_last,
                   clear: out_beat && run_last};

    tnrs_chain u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sort_key     (sort_key_reg),
        .new_rec      (new_rec),
        .head         (head),
        .second_valid (second_valid),
        .full         (full)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (in_beat && list_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_beat && run_last)
                begin
                    state_next = ST_FILL;
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_FILL: in_ready  = 1'b1;
            ST_EMIT: out_valid = 1'b1;
            default: in_ready  = 1'b0;
        endcase
    end

    always_comb
    begin
        emit_cnt_next = emit_cnt_reg;
        dropped_next  = dropped_reg;
        if (in_beat && full)
        begin
            dropped_next = 1'b1;
        end
        if (out_beat)
        begin
            emit_cnt_next = run_last ? '0 : emit_cnt_reg + CNT_W'(1);
            if (run_last)
            begin
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            sort_key_reg <= 1'b0;
            top_n_reg    <= '0;
            emit_cnt_reg <= '0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sort_key_reg <= sort_key_next;
            top_n_reg    <= top_n_next;
            emit_cnt_reg <= emit_cnt_next;
            dropped_reg  <= dropped_next;
        end
    end

    assign rank          = emit_cnt_reg[RANK_W-1:0];
    assign out_id        = head.id;
    assign out_cpu_centi = head.cpu;
    assign out_mem_bytes = head.mem;
    assign out_run_state = head.status;
    assign overflow      = dropped_reg;

endmodule

>>> hdl/tnrs_cell.sv
// ----------------------------------------------------------------------------
// Selector cell
// Holds one record of the sorted chain and trades records with its neighbors.
// ----------------------------------------------------------------------------
module tnrs_cell
    import tnrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chain_cmd_t cmd,
    input  logic       sort_key,
    input  rec_t       new_rec,
    input  rec_t       prev_rec,
    input  logic       prev_gb,
    input  rec_t       next_rec,
    output rec_t       rec,
    output logic       gb
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] id_reg;
    logic [31:0] id_next;
    logic [15:0] cpu_reg;
    logic [15:0] cpu_next;
    logic [47:0] mem_reg;
    logic [47:0] mem_next;
    logic [2:0]  status_reg;
    logic [2:0]  status_next;
    logic [47:0] key_new;
    logic [47:0] key_own;
    rec_t        take;
    logic        load;

    assign key_new = (sort_key == KEY_MEMORY) ? new_rec.mem : {32'b0, new_rec.cpu};
    assign key_own = (sort_key == KEY_MEMORY) ? mem_reg : {32'b0, cpu_reg};

    // The new record goes ahead of this one when this slot is empty or it ranks higher.
    assign gb = !valid_reg || (key_new > key_own) ||
                ((key_new == key_own) && (new_rec.id < id_reg));

    always_comb
    begin
        take = next_rec;
        load = 1'b0;
        priority if (cmd.clear)
        begin
            load = 1'b0;
        end
        else if (cmd.insert)
        begin
            load = gb;
            take = prev_gb ? prev_rec : new_rec;
        end
        else if (cmd.shift_up)
        begin
            load = 1'b1;
            take = next_rec;
        end
    end

    always_comb
    begin
        valid_next  = load ? take.valid : valid_reg;
        id_next     = load ? take.id : id_reg;
        cpu_next    = load ? take.cpu : cpu_reg;
        mem_next    = load ? take.mem : mem_reg;
        status_next = load ? take.status : status_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        cpu_reg    <= cpu_next;
        mem_reg    <= mem_next;
        status_reg <= status_next;
    end

    assign rec = '{valid: valid_reg, id: id_reg, cpu: cpu_reg, mem: mem_reg,
                   status: status_reg};

endmodule

>>> hdl/tnrs_chain.sv
// ----------------------------------------------------------------------------
// Selector chain
// A row of cells kept in rank order; inserts broadcast, emission shifts upward.
// ----------------------------------------------------------------------------
module tnrs_chain
    import tnrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chain_cmd_t cmd,
    input  logic       sort_key,
    input  rec_t       new_rec,
    output rec_t       head,
    output logic       second_valid,
    output logic       full
);

    rec_t recs [CAPACITY];
    logic gbs  [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            rec_t prev_r;
            logic prev_g;
            rec_t next_r;

            if (i == 0)
            begin : g_first
                assign prev_r = '0;
                assign prev_g = 1'b0;
            end
            else
            begin : g_mid
                assign prev_r = recs[i-1];
                assign prev_g = gbs[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign next_r = '0;
            end
            else
            begin : g_inner
                assign next_r = recs[i+1];
            end

            tnrs_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .sort_key (sort_key),
                .new_rec  (new_rec),
                .prev_rec (prev_r),
                .prev_gb  (prev_g),
                .next_rec (next_r),
                .rec      (recs[i]),
                .gb       (gbs[i])
            );
        end
    endgenerate

    assign head         = recs[0];
    assign second_valid = recs[1].valid;
    assign full         = recs[CAPACITY-1].valid;

endmodule

>>> hdl/tnrs_checker.sv
// ----------------------------------------------------------------------------
// Top-N record selector checker
// Port-level assertions on beat ordering and ranking, bound to the top level.
// ----------------------------------------------------------------------------
module tnrs_checker
    import tnrs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              list_end,
    input logic              out_valid,
    input logic              out_ready,
    input logic [RANK_W-1:0] rank,
    input logic [31:0]       out_id,
    input logic              run_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(rank))
        else $error("Result beat changed while stalled.");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("Input taken while results are pending.");

    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && list_end |=> out_valid && (rank == '0))
        else $error("Emission did not start at rank zero.");

    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=>
            out_valid && (rank == $past(rank) + RANK_W'(1)))
        else $error("Rank did not advance by one.");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && run_last |=> !out_valid && in_ready)
        else $error("Results continued after the last beat.");

endmodule

bind top_n_record_selector tnrs_checker u_tnrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .list_end  (list_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rank      (rank),
    .out_id    (out_id),
    .run_last  (run_last)
);
